>>> design/glyph_box_scanner_top_defines.svh
// Assertion macros used by the glyph box scanner checker
`ifndef GLYPH_BOX_SCANNER_TOP_DEFINES_SVH
`define GLYPH_BOX_SCANNER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define GBS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define GBS_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> design/gbs_pkg.sv
// Shared types, constants and helpers of the glyph box scanner
package gbs_pkg;

  localparam int PIX_W  = 32;
  localparam int ADDR_W = 16;
  localparam int DIM_W  = 9;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 16;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DIM_LIMIT      = 256;

  localparam logic [DIM_W-1:0] DIM_RESET  = 9'd256;
  localparam logic [DIM_W-1:0] DIM_MIN    = 9'd2;
  localparam logic [CNT_W-1:0] FIRST_CODE = 16'd32;

  // Command codes of the input word
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Pixel memory access from the scan controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Limit a sheet dimension to the range 2..hi
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

>>> design/gbs_pixel_mem.sv
// Pixel store: one write port, one registered read port
module gbs_pixel_mem (
  input  logic                         clk,
  input  gbs_pkg::mem_req_t            req,
  output logic [gbs_pkg::PIX_W-1:0]    rdata
);
  import gbs_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0] mem_q [0:DEPTH-1];
  logic [PIX_W-1:0] rdata_r;

  // Write a pixel
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
  end

  // Registered read, data ready in the cycle after the request
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_q[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/gbs_scan_ctrl.sv
// Command sequencer: pixel writes, rewind and the glyph corner scan
module gbs_scan_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [15:0]                 in_pixel_index,
  input  logic [31:0]                 in_pixel_value,
  input  logic [gbs_pkg::DIM_W-1:0]   w_use,
  input  logic [gbs_pkg::DIM_W-1:0]   h_use,
  output gbs_pkg::mem_req_t           mem_req,
  input  logic [gbs_pkg::PIX_W-1:0]   mem_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [7:0]                  out_box_x,
  output logic [7:0]                  out_box_y,
  output logic [7:0]                  out_box_width,
  output logic [7:0]                  out_box_height,
  output logic [15:0]                 out_char_code
);
  import gbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BG, S_POS, S_C0, S_C1, S_C2, S_C3,
    S_WSTART, S_WID, S_HSTART, S_HGT, S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             done_r, done_nxt;
  logic [POS_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [PIX_W-1:0] bg_r, bg_nxt;
  logic [POS_W-1:0] gw_r, gw_nxt, gh_r, gh_nxt;
  logic             found_r, found_nxt;

  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_x_r, out_y_r, out_w_r, out_h_r;
  logic [CNT_W-1:0] out_code_r;
  logic             out_load;

  logic               rd_en;
  logic [DIM_W-1:0]   rd_x, rd_y;
  logic [2*DIM_W-1:0] row_off;
  logic [2*DIM_W:0]   addr_sum;

  logic [DIM_W-1:0] w_m1, h_m1;
  logic [DIM_W-1:0] px9, py9, ny9;
  logic             wrap;
  logic [DIM_W:0]   wcol, hrow;
  logic [CNT_W:0]   code_wide;
  logic [CNT_W-1:0] code;
  logic             pix_is_bg;

  assign w_m1 = w_use - 9'd1;
  assign h_m1 = h_use - 9'd1;
  assign px9  = {1'b0, x_r};
  assign py9  = {1'b0, y_r};
  assign wrap = px9 >= w_m1;
  assign ny9  = wrap ? py9 + 9'd1 : py9;
  assign wcol = {2'b00, x_r} + {2'b00, gw_r} + 10'd1;
  assign hrow = {2'b00, y_r} + {2'b00, gh_r} + 10'd1;
  assign pix_is_bg = (mem_rdata == bg_r);

  // Code of the next glyph, saturated
  assign code_wide = {1'b0, count_r} + {1'b0, FIRST_CODE};
  assign code      = code_wide[CNT_W] ? {CNT_W{1'b1}} : code_wide[CNT_W-1:0];

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Sequence the commands and the scan
  always_comb begin
    state_nxt = state_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    bg_nxt    = bg_r;
    gw_nxt    = gw_r;
    gh_nxt    = gh_r;
    found_nxt = found_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_x      = '0;
    rd_y      = '0;
    mem_req.we    = 1'b0;
    mem_req.waddr = in_pixel_index;
    mem_req.wdata = in_pixel_value;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_WRITE: begin
              mem_req.we = 1'b1;
            end
            CMD_REWIND: begin
              cur_x_nxt = '0;
              cur_y_nxt = '0;
              count_nxt = '0;
              done_nxt  = 1'b0;
            end
            CMD_FIND: begin
              // fetch the background pixel
              rd_en     = 1'b1;
              x_nxt     = cur_x_r;
              y_nxt     = cur_y_r;
              state_nxt = S_BG;
            end
            default: begin
            end
          endcase
        end
      end
      S_BG: begin
        bg_nxt = mem_rdata;
        if (done_r || py9 >= h_m1) begin
          done_nxt  = 1'b1;
          found_nxt = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        // wrap to the next row at the right edge, stop at the bottom
        if (wrap && ny9 >= h_m1) begin
          done_nxt  = 1'b1;
          found_nxt = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          x_nxt     = wrap ? '0 : x_r;
          y_nxt     = ny9[POS_W-1:0];
          rd_en     = 1'b1;
          rd_x      = wrap ? 9'd1 : px9 + 9'd1;
          rd_y      = ny9 + 9'd1;
          state_nxt = S_C0;
        end
      end
      S_C0: begin
        // lower right must differ from the background
        if (pix_is_bg) begin
          x_nxt     = x_r + 8'd1;
          state_nxt = S_POS;
        end else begin
          rd_en     = 1'b1;
          rd_x      = px9;
          rd_y      = py9;
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        if (!pix_is_bg) begin
          x_nxt     = x_r + 8'd1;
          state_nxt = S_POS;
        end else begin
          rd_en     = 1'b1;
          rd_x      = px9 + 9'd1;
          rd_y      = py9;
          state_nxt = S_C2;
        end
      end
      S_C2: begin
        if (!pix_is_bg) begin
          x_nxt     = x_r + 8'd1;
          state_nxt = S_POS;
        end else begin
          rd_en     = 1'b1;
          rd_x      = px9;
          rd_y      = py9 + 9'd1;
          state_nxt = S_C3;
        end
      end
      S_C3: begin
        if (!pix_is_bg) begin
          x_nxt     = x_r + 8'd1;
          state_nxt = S_POS;
        end else begin
          gw_nxt    = 8'd1;
          state_nxt = S_WSTART;
        end
      end
      S_WSTART: begin
        // measure along the row below the corner
        if (wcol < {1'b0, w_use}) begin
          rd_en     = 1'b1;
          rd_x      = wcol[DIM_W-1:0];
          rd_y      = py9 + 9'd1;
          state_nxt = S_WID;
        end else begin
          gh_nxt    = 8'd1;
          state_nxt = S_HSTART;
        end
      end
      S_WID: begin
        if (!pix_is_bg) begin
          gw_nxt    = gw_r + 8'd1;
          state_nxt = S_WSTART;
        end else begin
          gh_nxt    = 8'd1;
          state_nxt = S_HSTART;
        end
      end
      S_HSTART: begin
        // measure down the column right of the corner
        if (hrow < {1'b0, h_use}) begin
          rd_en     = 1'b1;
          rd_x      = px9 + 9'd1;
          rd_y      = hrow[DIM_W-1:0];
          state_nxt = S_HGT;
        end else begin
          found_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_HGT: begin
        if (!pix_is_bg) begin
          gh_nxt    = gh_r + 8'd1;
          state_nxt = S_HSTART;
        end else begin
          found_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hand over the result and advance the cursor
        if (out_load) begin
          if (found_r) begin
            if (count_r != {CNT_W{1'b1}}) count_nxt = count_r + 16'd1;
            cur_x_nxt = x_r + gw_r;
            cur_y_nxt = y_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Raster address of the pixel being read, modulo the store size
    row_off  = {{DIM_W{1'b0}}, rd_y} * {{DIM_W{1'b0}}, w_use};
    addr_sum = {1'b0, row_off} + {{(DIM_W+1){1'b0}}, rd_x};

    mem_req.re    = rd_en;
    mem_req.raddr = addr_sum[ADDR_W-1:0];
  end

  // Hold control state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan working registers and output payload
  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    bg_r <= bg_nxt;
    gw_r <= gw_nxt;
    gh_r <= gh_nxt;
    if (out_load) begin
      out_found_r <= found_r;
      out_x_r     <= found_r ? x_r  : '0;
      out_y_r     <= found_r ? y_r  : '0;
      out_w_r     <= found_r ? gw_r : '0;
      out_h_r     <= found_r ? gh_r : '0;
      out_code_r  <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_box_x      = out_x_r;
  assign out_box_y      = out_y_r;
  assign out_box_width  = out_w_r;
  assign out_box_height = out_h_r;
  assign out_char_code  = out_code_r;

endmodule

>>> design/glyph_box_scanner_top.sv
// Glyph box scanner top level: configuration registers, sequencer, pixel store
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | in_cmd, in_pixel_index, in_pixel_value
//   out     | out_valid / out_ready| out_found, out_box_*, out_char_code
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// Pixel write, rewind and unused commands are taken in the idle state.
// A find reads the background pixel, then at each scanned corner position up to
// four corner pixels, moving on at the first failing pixel, then measures width and
// height pixel by pixel and emits; a find at the end of the sheet skips the measures.
// Every read, one pixel each, goes through the single read port of the pixel store.
// Synchronous reset clears cursor, count and flags; the pixel store is not cleared.
// The result sits in an output register; a find waits there only if the
// previous word is still untaken.
module glyph_box_scanner_top #(
  parameter int MAX_WIDTH  = gbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gbs_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_pixel_index,
  input  logic [31:0] in_pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_box_x,
  output logic [7:0]  out_box_y,
  output logic [7:0]  out_box_width,
  output logic [7:0]  out_box_height,
  output logic [15:0] out_char_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import gbs_pkg::*;

  localparam int WCapInt = (MAX_WIDTH  < DIM_LIMIT) ? MAX_WIDTH  : DIM_LIMIT;
  localparam int HCapInt = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
  localparam logic [DIM_W-1:0] W_CAP = DIM_W'(WCapInt);
  localparam logic [DIM_W-1:0] H_CAP = DIM_W'(HCapInt);

  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] w_use, h_use;
  mem_req_t         mem_req;
  logic [PIX_W-1:0] mem_rdata;

  // Hold the sheet dimensions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign w_use = clamp_dim(width_r, W_CAP);
  assign h_use = clamp_dim(height_r, H_CAP);

  gbs_scan_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_pixel_index (in_pixel_index),
    .in_pixel_value (in_pixel_value),
    .w_use          (w_use),
    .h_use          (h_use),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_box_x      (out_box_x),
    .out_box_y      (out_box_y),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .out_char_code  (out_char_code)
  );

  gbs_pixel_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

>>> design/gbs_checker.sv
// Port-level checks of the glyph box scanner, bound to the top level
`include "glyph_box_scanner_top_defines.svh"

module gbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic [15:0] in_pixel_index,
  input logic [31:0] in_pixel_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [7:0]  out_box_x,
  input logic [7:0]  out_box_y,
  input logic [7:0]  out_box_width,
  input logic [7:0]  out_box_height,
  input logic [15:0] out_char_code,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [8:0]  cfg_data
);

  // Stalled result word holds
  `GBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char_code) && $stable(out_box_x) && $stable(out_found), "stalled result changed")

  // A miss carries an empty box
  `GBS_ASSERT_ALWAYS(a_miss_empty, !out_valid || out_found || (out_box_x == 8'd0 && out_box_y == 8'd0 && out_box_width == 8'd0 && out_box_height == 8'd0), "miss with nonzero box")

  // A hit has a box of at least one pixel each way
  `GBS_ASSERT_ALWAYS(a_hit_size, !out_valid || !out_found || (out_box_width != 8'd0 && out_box_height != 8'd0), "hit with empty box")

  // Codes never fall below the first printable code
  `GBS_ASSERT_ALWAYS(a_code_min, !out_valid || out_char_code >= 16'd32, "char code below first code")

endmodule

bind glyph_box_scanner_top gbs_checker u_gbs_checker (.*);

>>> test/glyph_box_scanner_top_test.sv
// Self-checking testbench of the glyph box scanner: font sheets, finds and rewinds
`timescale 1ns / 100ps

module glyph_box_scanner_top_test;
  import gbs_pkg::*;

  localparam int WORD_TARGET = 1950;
  localparam int SETTLE      = 32;
  localparam int CYCLE_LIMIT = 5000000;

  // One input word and one glyph box result
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] index;
    logic [31:0] value;
  } scan_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] code;
  } glyph_box_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd         = CMD_NONE;
  logic [15:0] in_pixel_index = '0;
  logic [31:0] in_pixel_value = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_found;
  logic [7:0]  out_box_x;
  logic [7:0]  out_box_y;
  logic [7:0]  out_box_width;
  logic [7:0]  out_box_height;
  logic [15:0] out_char_code;
  logic        cfg_we         = 1'b0;
  logic        cfg_index      = REG_WIDTH;
  logic [8:0]  cfg_data       = '0;

  glyph_box_scanner_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_pixel_index (in_pixel_index),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_box_x      (out_box_x),
    .out_box_y      (out_box_y),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .out_char_code  (out_char_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Scanner state as the testbench sees it
  logic [31:0] pixel_copy  [0:65535];
  logic [31:0] sheet_draft [0:65535];
  logic [8:0]  width_reg   = DIM_RESET;
  logic [8:0]  height_reg  = DIM_RESET;
  int unsigned cur_x       = 0;
  int unsigned cur_y       = 0;
  int unsigned glyph_total = 0;
  logic        sheet_end   = 1'b0;

  scan_word_t cmd_backlog[$];
  glyph_box_t pending_boxes[$];

  int words_queued  = 0;
  int words_taken   = 0;
  int finds_seen    = 0;
  int glyphs_seen   = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int phases_run    = 0;
  int cycle_count   = 0;
  int burst_left    = 4;
  int gap_left      = 0;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [7:0]  mask_age   = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp a raw register value to the sheet size in use
  function automatic int unsigned fit_dim(input logic [8:0] raw);
    if (raw < 2) return 2;
    if (raw > DIM_LIMIT) return DIM_LIMIT;
    return raw;
  endfunction

  function automatic logic [31:0] px(input int unsigned x, input int unsigned y,
                                     input int unsigned w);
    return pixel_copy[(x + y * w) & 32'hFFFF];
  endfunction

  // Advance the scanner copy by one accepted word; queue the box it yields
  task automatic apply_word(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [31:0] pix_val);
    int unsigned w, h, x, y, gw, gh, code;
    logic [31:0] bg;
    logic        hunting;
    glyph_box_t  box;
    w = fit_dim(width_reg);
    h = fit_dim(height_reg);
    code = glyph_total + FIRST_CODE;
    if (code > 65535) code = 65535;
    case (cmd)
      CMD_WRITE: pixel_copy[addr] = pix_val;
      CMD_REWIND: begin
        cur_x = 0;
        cur_y = 0;
        glyph_total = 0;
        sheet_end = 1'b0;
      end
      CMD_FIND: begin
        finds_seen++;
        bg = pixel_copy[0];
        x = cur_x;
        y = cur_y;
        if (y >= h - 1) sheet_end = 1'b1;
        hunting = !sheet_end;
        // walk right, wrapping rows, until a corner window or the bottom
        while (hunting) begin
          if (x >= w - 1) begin
            x = 0;
            y++;
          end
          if (y >= h - 1) begin
            sheet_end = 1'b1;
            hunting = 1'b0;
          end else if (px(x, y, w) == bg && px(x + 1, y, w) == bg &&
                       px(x, y + 1, w) == bg && px(x + 1, y + 1, w) != bg) begin
            hunting = 1'b0;
          end else begin
            x++;
          end
        end
        box = '0;
        box.code = code[15:0];
        if (!sheet_end) begin
          gw = 1;
          while (x + gw + 1 < w && px(x + gw + 1, y + 1, w) != bg) gw++;
          gh = 1;
          while (y + gh + 1 < h && px(x + 1, y + gh + 1, w) != bg) gh++;
          box.found = 1'b1;
          box.x = x[7:0];
          box.y = y[7:0];
          box.w = gw[7:0];
          box.h = gh[7:0];
          if (glyph_total < 65535) glyph_total++;
          cur_x = (x + gw) & 8'hFF;
          cur_y = y & 8'hFF;
          glyphs_seen++;
        end
        pending_boxes.push_back(box);
      end
      default: ;
    endcase
  endtask

  // Driver: present queued words in bursts, hold each until taken
  always @(posedge clk) begin : feed
    scan_word_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 4;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_word(in_cmd, in_pixel_index, in_pixel_value);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          in_valid       <= 1'b1;
          in_cmd         <= nxt.cmd;
          in_pixel_index <= nxt.index;
          in_pixel_value <= nxt.value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, reshuffled each time the 8-bit age counter wraps
  always @(posedge clk) begin
    if (mask_age == 0)
      stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    out_ready <= stall_mask[mask_age[3:0]];
    mask_age  <= mask_age + 8'd1;
  end

  // Monitor: check each taken result against the oldest expected box
  always @(posedge clk) begin : watch
    glyph_box_t got, want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      got.found = out_found;
      got.x     = out_box_x;
      got.y     = out_box_y;
      got.w     = out_box_width;
      got.h     = out_box_height;
      got.code  = out_char_code;
      if (pending_boxes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d with no box expected: found=%0d x=%0d y=%0d w=%0d h=%0d code=%0d",
                   results_seen, got.found, got.x, got.y, got.w, got.h, got.code);
      end else begin
        want = pending_boxes.pop_front();
        if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
            got.w !== want.w || got.h !== want.h || got.code !== want.code) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d mismatch: expected found=%0d x=%0d y=%0d w=%0d h=%0d code=%0d, got found=%0d x=%0d y=%0d w=%0d h=%0d code=%0d",
                     results_seen, want.found, want.x, want.y, want.w, want.h, want.code,
                     got.found, got.x, got.y, got.w, got.h, got.code);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d boxes outstanding", cycle_count,
               pending_boxes.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_word(input cmd_t cmd, input logic [15:0] addr,
                            input logic [31:0] pix_val);
    scan_word_t wd;
    wd.cmd   = cmd;
    wd.index = addr;
    wd.value = pix_val;
    cmd_backlog.push_back(wd);
    words_queued++;
  endtask

  // Hold until every word is taken and every box has come back
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || pending_boxes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // Draw a sheet of glyph boxes on a background and queue its pixel writes
  task automatic load_sheet(input int unsigned w, input int unsigned h);
    int unsigned xb, yb, bw, bh, xx, yy, i;
    logic [31:0] bg, ink;
    case ($urandom_range(0, 3))
      0:       bg = 32'h0000_0000;
      1:       bg = 32'hFFFF_FFFF;
      default: bg = $urandom();
    endcase
    for (i = 0; i < w * h; i++) sheet_draft[i] = bg;
    yb = 1;
    while (yb < h) begin
      bh = $urandom_range(1, 4);
      xb = $urandom_range(1, 2);
      while (xb < w) begin
        bw = $urandom_range(1, 5);
        for (yy = yb; yy < yb + bh && yy < h; yy++)
          for (xx = xb; xx < xb + bw && xx < w; xx++) begin
            ink = $urandom();
            if (ink == bg) ink = ~bg;
            // leave an odd hole inside a box
            sheet_draft[yy * w + xx] = ($urandom_range(0, 9) == 0) ? bg : ink;
          end
        xb += bw + $urandom_range(1, 3);
      end
      yb += bh + $urandom_range(1, 2);
    end
    // sprinkle stray pixels, keeping the corner pixel as background
    for (i = 1; i < w * h; i++)
      if ($urandom_range(0, 31) == 0) sheet_draft[i] = $urandom();
    for (i = 0; i < w * h; i++) queue_word(CMD_WRITE, i[15:0], sheet_draft[i]);
  endtask

  // One sheet setting: set the size, load a sheet, then a random mix of words
  task automatic run_phase(input logic [8:0] wraw, input logic [8:0] hraw, input int ncmds);
    int unsigned w, h, r, k;
    logic [31:0] v;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_WIDTH, wraw);
    write_reg(REG_HEIGHT, hraw);
    w = fit_dim(wraw);
    h = fit_dim(hraw);
    load_sheet(w, h);
    // find before any rewind, so the cursor carries over from the last size
    queue_word(CMD_FIND, 16'($urandom_range(0, 65535)), $urandom());
    for (k = 0; k < ncmds; k++) begin
      if (k == ncmds / 2 && (phases_run == 1 || $urandom_range(0, 3) == 0)) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 58) begin
        queue_word(CMD_FIND, 16'($urandom_range(0, 65535)), $urandom());
      end else if (r < 68) begin
        queue_word(CMD_REWIND, 16'($urandom_range(0, 65535)), $urandom());
      end else if (r < 83) begin
        v = ($urandom_range(0, 2) == 0) ? pixel_copy[0] : $urandom();
        queue_word(CMD_WRITE, 16'($urandom_range(0, w * h - 1)), v);
      end else if (r < 91) begin
        queue_word(CMD_WRITE, 16'($urandom_range(0, 65535)), $urandom());
      end else begin
        queue_word(CMD_NONE, 16'($urandom_range(0, 65535)), $urandom());
      end
    end
    phases_run++;
  endtask

  // Stimulus
  initial begin : stimulus
    logic [8:0] wraw, hraw;
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed 4x3 sheet: a glyph at the top-left and one on the last corner row
    write_reg(REG_WIDTH, 9'd4);
    write_reg(REG_HEIGHT, 9'd3);
    for (i = 0; i < 12; i++)
      queue_word(CMD_WRITE, i[15:0], (i == 5) ? 32'hFFFF_FFFF :
                                     (i == 11) ? 32'h8000_0001 : 32'h0000_0000);
    queue_word(CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    // two boxes, then the end of the sheet twice
    repeat (4) queue_word(CMD_FIND, 16'($urandom_range(0, 65535)), $urandom());
    queue_word(CMD_REWIND, 16'h0000, 32'h0000_0000);
    // leave the cursor on the last corner row for the next, shorter sheet
    repeat (2) queue_word(CMD_FIND, 16'($urandom_range(0, 65535)), $urandom());
    phases_run++;

    // size extremes, clamped from out-of-range values
    run_phase(9'd1, 9'd0, 30);
    run_phase(9'd511, 9'd1, 40);
    run_phase(9'd0, 9'd300, 40);

    // small random sheets until the word budget is spent
    while (words_queued < WORD_TARGET) begin
      wraw = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1)) :
                                           9'($urandom_range(2, 20));
      hraw = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1)) :
                                           9'($urandom_range(2, 10));
      run_phase(wraw, hraw, $urandom_range(25, 60));
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Checked %0d results from %0d words over %0d sheet sizes", results_seen,
             words_taken, phases_run);
    $display("Finds issued: %0d, glyph boxes located: %0d", finds_seen, glyphs_seen);
    if (fail_count == 0 && pending_boxes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures, %0d boxes never returned", fail_count, pending_boxes.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
